@@ rtl/pqsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority queue package
// Sizes, codes, controller types and the compare node of the search tree.
// ----------------------------------------------------------------------------
package pqsr_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int TREE_N   = 2 ** IDX_W;
  localparam int PRIO_W   = 16;
  localparam int DATA_W   = 32;
  localparam int FILL_W   = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } pqsr_status_e;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } pqsr_kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } pqsr_state_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } pqsr_cmd_t;

  typedef struct packed {
    logic                     valid;
    logic signed [PRIO_W-1:0] prio;
    logic signed [DATA_W-1:0] data;
    logic [IDX_W-1:0]         idx;
  } pqsr_node_t;

  // The left node holds the older entries, so it wins a tie.
  function automatic pqsr_node_t pqsr_pick(pqsr_node_t left, pqsr_node_t right);
    pqsr_node_t res;
    if (right.valid && (!left.valid || (right.prio > left.prio))) begin
      res = right;
    end else begin
      res = left;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ rtl/pqsr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority queue controller
// Takes a command beat while idle and runs its execute cycle.
// ----------------------------------------------------------------------------
module pqsr_ctrl
  import pqsr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  output pqsr_cmd_t cmd_o
);

  pqsr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    busy_o        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        busy_o        = 1'b1;
        cmd_o.execute = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/pqsr_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority queue datapath
// Entry cells in arrival order, a compare tree for the best entry and the
// result registers.
// ----------------------------------------------------------------------------
module pqsr_dp
  import pqsr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pqsr_cmd_t                cmd_i,
  input  logic                     kind_i,
  input  logic signed [PRIO_W-1:0] new_priority_i,
  input  logic signed [DATA_W-1:0] new_data_i,
  output logic                     done_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic signed [PRIO_W-1:0] out_priority_o,
  output logic signed [DATA_W-1:0] out_data_o,
  output logic [FILL_W-1:0]        fill_level_o
);

  logic signed [PRIO_W-1:0] prio_q [DEPTH];
  logic signed [DATA_W-1:0] data_q [DEPTH];
  logic [CNT_W-1:0]         cnt_q;

  pqsr_kind_e               kind_q;
  logic signed [PRIO_W-1:0] new_prio_q;
  logic signed [DATA_W-1:0] new_data_q;
  pqsr_node_t               win_q;

  logic                     done_q;
  pqsr_status_e             status_q;
  logic signed [PRIO_W-1:0] res_prio_q;
  logic signed [DATA_W-1:0] res_data_q;
  logic [CNT_W-1:0]         res_cnt_q;

  pqsr_node_t               leaf [TREE_N];
  pqsr_node_t               node [1:2*TREE_N-1];
  logic                     is_full;
  logic                     is_empty;
  logic                     do_enq;
  logic                     do_deq;
  logic [CNT_W+FILL_W-1:0]  fill_ext;

  for (genvar g = 0; g < TREE_N; g++) begin : g_leaf
    if (g < DEPTH) begin : g_cell
      assign leaf[g].valid = (CNT_W'(g) < cnt_q);
      assign leaf[g].prio  = prio_q[g];
      assign leaf[g].data  = data_q[g];
      assign leaf[g].idx   = IDX_W'(g);
    end else begin : g_pad
      assign leaf[g] = '0;
    end
  end

  always_comb begin
    for (int k = 0; k < TREE_N; k++) begin
      node[(IDX_W+1)'(TREE_N + k)] = leaf[IDX_W'(k)];
    end
    for (int k = TREE_N - 1; k >= 1; k--) begin
      node[(IDX_W+1)'(k)] = pqsr_pick(node[(IDX_W+1)'(2*k)], node[(IDX_W+1)'(2*k+1)]);
    end
  end

  assign is_full  = (cnt_q == CNT_W'(DEPTH));
  assign is_empty = (cnt_q == '0);
  assign do_enq   = cmd_i.execute && (kind_q == KIND_ENQ) && !is_full;
  assign do_deq   = cmd_i.execute && (kind_q == KIND_DEQ) && !is_empty;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q     <= pqsr_kind_e'(kind_i);
      new_prio_q <= new_priority_i;
      new_data_q <= new_data_i;
      win_q      <= node[1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (do_enq && (CNT_W'(i) == cnt_q)) begin
        prio_q[IDX_W'(i)] <= new_prio_q;
        data_q[IDX_W'(i)] <= new_data_q;
      end else if (do_deq && (i < DEPTH - 1) && (IDX_W'(i) >= win_q.idx)) begin
        prio_q[IDX_W'(i)] <= prio_q[IDX_W'(i + 1)];
        data_q[IDX_W'(i)] <= data_q[IDX_W'(i + 1)];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.execute;
      if (do_enq) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_deq) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      res_prio_q <= '0;
      res_data_q <= '0;
      if (kind_q == KIND_ENQ) begin
        if (is_full) begin
          status_q  <= STATUS_FULL;
          res_cnt_q <= cnt_q;
        end else begin
          status_q  <= STATUS_OK;
          res_cnt_q <= cnt_q + CNT_W'(1);
        end
      end else if (is_empty) begin
        status_q  <= STATUS_EMPTY;
        res_cnt_q <= '0;
      end else begin
        status_q   <= STATUS_OK;
        res_prio_q <= win_q.prio;
        res_data_q <= win_q.data;
        res_cnt_q  <= cnt_q - CNT_W'(1);
      end
    end
  end

  assign fill_ext       = {{FILL_W{1'b0}}, res_cnt_q};
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign out_priority_o = res_prio_q;
  assign out_data_o     = res_data_q;
  assign fill_level_o   = fill_ext[FILL_W-1:0];

endmodule
`default_nettype wire

@@ rtl/priority_queue_scan_remove.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded priority queue
// Enqueue appends at the young end; dequeue removes the highest priority,
// the oldest entry winning a tie, and the rest keep their arrival order.
// ----------------------------------------------------------------------------
// A command beat is taken on a rising edge with start high and busy low:
// kind_i selects enqueue or dequeue, and new_priority_i and new_data_i carry
// the entry to enqueue. The command is executed in the following cycle,
// during which busy is high.
// Each command gives one result beat, shown for exactly one cycle with
// done_o high; done_o is registered from the execute strobe. A new command
// can be given in the same cycle as that result.
// The best entry is found by a compare tree over all cells during the
// command cycle; the removal shifts the younger cells down by one in the
// execute cycle.
// The receiver cannot stall: a result beat must be taken when shown.
// Reset empties the queue and clears the controller; the cells are not
// cleared, as cells at or above the fill count are never selected.
// ----------------------------------------------------------------------------
module priority_queue_scan_remove
  import pqsr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     kind_i,
  input  logic signed [PRIO_W-1:0] new_priority_i,
  input  logic signed [DATA_W-1:0] new_data_i,
  output logic                     done_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic signed [PRIO_W-1:0] out_priority_o,
  output logic signed [DATA_W-1:0] out_data_o,
  output logic [FILL_W-1:0]        fill_level_o
);

  pqsr_cmd_t cmd;

  pqsr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .cmd_o   (cmd)
  );

  pqsr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .kind_i         (kind_i),
    .new_priority_i (new_priority_i),
    .new_data_i     (new_data_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .out_priority_o (out_priority_o),
    .out_data_o     (out_data_o),
    .fill_level_o   (fill_level_o)
  );

endmodule
`default_nettype wire

@@ rtl/pqsr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Priority queue checker
// Port-level properties of the command and result beats.
// ----------------------------------------------------------------------------
module pqsr_checker
  import pqsr_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_i,
  input logic                     done_i,
  input logic [STATUS_W-1:0]      status_i,
  input logic signed [PRIO_W-1:0] out_priority_i,
  input logic signed [DATA_W-1:0] out_data_i,
  input logic [FILL_W-1:0]        fill_level_i
);

  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> busy_i)
    else $error("busy not raised after a command beat");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_i |=> ##1 done_i)
    else $error("result beat missing two cycles after a command beat");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> !busy_i)
    else $error("result beat shown while busy");

  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && (status_i != STATUS_OK) |-> (out_priority_i == '0) && (out_data_i == '0))
    else $error("non-zero entry on a failed command");

  a_full_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i && (status_i == STATUS_FULL) |-> (fill_level_i == FILL_W'(DEPTH)))
    else $error("full status with a fill level below the depth");

endmodule

bind priority_queue_scan_remove pqsr_checker u_pqsr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start),
  .busy_i         (busy),
  .done_i         (done_o),
  .status_i       (status_o),
  .out_priority_i (out_priority_o),
  .out_data_i     (out_data_o),
  .fill_level_i   (fill_level_o)
);
`default_nettype wire
